### hw/rtl/m4i_pkg.sv
// ----------------------------------------------------------------------------
// m4i_pkg: shared types and constants of the 4x4 matrix inverse
// Widths of the fixed-point datapath and the divider request and response.
// ----------------------------------------------------------------------------
package m4i_pkg;

  localparam int EW     = 32;
  localparam int FB     = 16;
  localparam int MUL_W  = EW + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ADJ_W  = 3 * EW + 2;
  localparam int ACC_W  = 4 * EW + 4;
  localparam int NUM_W  = ADJ_W + 2 * FB;
  localparam int Q_W    = EW + 1;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [MUL_W-1:0] mul_op_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [ACC_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic           ovf;
    logic [Q_W-1:0] quo;
  } div_rsp_t;

endpackage

### hw/rtl/m4i_ifs.sv
// ----------------------------------------------------------------------------
// m4i_ifs: word channels of the 4x4 matrix inverse
// Element input channel and inverse result channel with valid and ready.
// ----------------------------------------------------------------------------
interface m4i_in_if;
  logic                  valid;
  logic                  ready;
  logic signed [m4i_pkg::EW-1:0] element_value;
  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

interface m4i_out_if;
  logic                  valid;
  logic                  ready;
  logic signed [m4i_pkg::EW-1:0] inverse_value;
  logic [3:0]            element_index;
  logic                  singular;
  logic                  saturated;
  logic                  last_of_run;
  modport source (output valid, output inverse_value, output element_index,
                  output singular, output saturated, output last_of_run, input ready);
  modport sink (input valid, input inverse_value, input element_index,
                input singular, input saturated, input last_of_run, output ready);
endinterface

### hw/rtl/m4i_mul.sv
// ----------------------------------------------------------------------------
// m4i_mul: shared signed multiplier
// One signed multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module m4i_mul (
  input  logic             clk,
  input  m4i_pkg::mul_op_t x_i,
  input  m4i_pkg::mul_op_t y_i,
  output m4i_pkg::prod_t   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= x_i * y_i;
  end

endmodule

### hw/rtl/m4i_div.sv
// ----------------------------------------------------------------------------
// m4i_div: restoring unsigned divider
// Produces one quotient bit per cycle and keeps the low quotient bits with a
// sticky flag for any higher bit that was set.
// ----------------------------------------------------------------------------
module m4i_div (
  input  logic              clk,
  input  logic              rst_n,
  input  m4i_pkg::div_req_t req,
  output m4i_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(m4i_pkg::NUM_W);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [m4i_pkg::NUM_W-1:0]   num_r;
  logic [m4i_pkg::ACC_W-1:0]   den_r;
  logic [m4i_pkg::ACC_W-1:0]   rem_r;
  logic [m4i_pkg::Q_W-1:0]     quo_r;
  logic                        ovf_r;
  logic [m4i_pkg::ACC_W:0]     trial;
  logic [m4i_pkg::ACC_W:0]     diff;
  logic                        ge;

  always_comb begin
    trial = {rem_r, num_r[m4i_pkg::NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        quo_r  <= '0;
        ovf_r  <= 1'b0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[m4i_pkg::ACC_W-1:0] : trial[m4i_pkg::ACC_W-1:0];
        num_r <= num_r << 1;
        quo_r <= {quo_r[m4i_pkg::Q_W-2:0], ge};
        ovf_r <= ovf_r | quo_r[m4i_pkg::Q_W-1];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(m4i_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.quo  = quo_r;

endmodule

### hw/rtl/matrix4_inverse_top.sv
// A 4x4 matrix is loaded one element word per cycle in column-major order. After the
// sixteenth word the block computes the sixteen cofactors exactly on one shared
// 33x33 multiplier, the determinant from the first column, and then each inverse
// element on a one-bit-per-cycle divider of 130 steps; a singular matrix gives its
// sixteen zero results without a division.
// Input is not accepted from the sixteenth element until the last result is taken.
// ----------------------------------------------------------------------------
// matrix4_inverse_top: 4x4 fixed-point matrix inverse by cofactors
// Sequencer around the element store, the shared multiplier and the divider.
// ----------------------------------------------------------------------------
module matrix4_inverse_top (
  input  logic       clk,
  input  logic       rst_n,
  m4i_in_if.sink     in_word,
  m4i_out_if.source  out_word
);

  localparam int EW    = m4i_pkg::EW;
  localparam int ADJ_W = m4i_pkg::ADJ_W;
  localparam int ACC_W = m4i_pkg::ACC_W;
  localparam int PROD_W = m4i_pkg::PROD_W;
  localparam int MUL_W = m4i_pkg::MUL_W;
  localparam int Q_W   = m4i_pkg::Q_W;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_COF  = 3'd1;
  localparam logic [2:0] S_DET  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  function automatic logic [3:0] cof_addr(input logic [3:0] p, input logic [2:0] t,
                                          input logic [1:0] f);
    logic [1:0] row, col, i, j1, j2, kr, kc, rr, cc;
    row = p[1:0];
    col = p[3:2];
    i   = t[2:1];
    j1  = (i == 2'd2) ? 2'd0 : i + 2'd1;
    j2  = (i == 2'd0) ? 2'd2 : i - 2'd1;
    case (f)
      2'd0: begin
        kr = 2'd0;
        kc = i;
      end
      2'd1: begin
        kr = 2'd1;
        kc = t[0] ? j2 : j1;
      end
      default: begin
        kr = 2'd2;
        kc = t[0] ? j1 : j2;
      end
    endcase
    rr = (kr < col) ? kr : kr + 2'd1;
    cc = (kc < row) ? kc : kc + 2'd1;
    return {cc, rr};
  endfunction

  logic [2:0]               state_r;
  logic [3:0]               load_cnt_r;
  m4i_pkg::elem_t           store_r [16];
  logic [ADJ_W-1:0]         adj_r [16];
  logic [3:0]               p_r;
  logic [2:0]               t_r;
  logic [2:0]               s_r;
  logic [1:0]               i_r;
  m4i_pkg::mul_op_t         a_r;
  logic [EW-1:0]            plo_r;
  logic [ACC_W-1:0]         acc_r;
  logic [ACC_W-1:0]         det_r;
  logic                     neg_r;
  logic [EW-1:0]            out_value_r;
  logic [3:0]               out_index_r;
  logic                     out_sing_r;
  logic                     out_sat_r;
  logic                     out_last_r;

  logic [3:0]               rd_addr;
  logic [1:0]               fsel;
  m4i_pkg::elem_t           elem;
  logic [3:0]               adj_addr;
  logic [ADJ_W-1:0]         adj_sel;
  m4i_pkg::mul_op_t         mul_x;
  m4i_pkg::mul_op_t         mul_y;
  m4i_pkg::mul_op_t         y_e;
  m4i_pkg::mul_op_t         y_n;
  m4i_pkg::prod_t           prod_r;
  logic                     term_neg;
  logic                     add_en;
  logic [1:0]               add_sh;
  logic [ACC_W-1:0]         prod_ext;
  logic [ACC_W-1:0]         addend;
  logic [ACC_W-1:0]         acc_nxt;
  logic                     det_zero;
  logic [ACC_W-1:0]         det_abs;
  logic [ADJ_W-1:0]         adj_abs;
  m4i_pkg::div_req_t        div_req;
  m4i_pkg::div_rsp_t        div_rsp;
  logic                     fits;
  logic [EW-1:0]            q_val;

  always_comb begin
    fsel = (s_r == 3'd0) ? 2'd0 : ((s_r == 3'd1) ? 2'd1 : 2'd2);
    rd_addr  = (state_r == S_DET) ? {2'b00, i_r} : cof_addr(p_r, t_r, fsel);
    elem     = store_r[rd_addr];
    adj_addr = (state_r == S_DET) ? {i_r, 2'b00} : p_r;
    adj_sel  = adj_r[adj_addr];
    y_e      = {elem[EW-1], elem};
    y_n      = -y_e;
    term_neg = t_r[0] ^ p_r[0] ^ p_r[2];
  end

  always_comb begin
    mul_x  = '0;
    mul_y  = '0;
    add_en = 1'b0;
    add_sh = 2'd0;
    if (state_r == S_COF) begin
      case (s_r)
        3'd1: begin
          mul_x = a_r;
          mul_y = y_e;
        end
        3'd2: begin
          mul_x = {prod_r[2*EW-1], prod_r[2*EW-1:EW]};
          mul_y = term_neg ? y_n : y_e;
        end
        3'd3: begin
          mul_x  = {1'b0, plo_r};
          mul_y  = term_neg ? y_n : y_e;
          add_en = 1'b1;
          add_sh = 2'd1;
        end
        3'd4: begin
          add_en = 1'b1;
        end
        default: begin
          add_en = 1'b0;
        end
      endcase
    end else if (state_r == S_DET) begin
      case (s_r)
        3'd0: begin
          mul_x = {1'b0, adj_sel[EW-1:0]};
          mul_y = y_e;
        end
        3'd1: begin
          mul_x  = {1'b0, adj_sel[2*EW-1:EW]};
          mul_y  = y_e;
          add_en = 1'b1;
        end
        3'd2: begin
          mul_x  = {1'b0, adj_sel[3*EW-1:2*EW]};
          mul_y  = y_e;
          add_en = 1'b1;
          add_sh = 2'd1;
        end
        3'd3: begin
          mul_x  = {{(MUL_W-(ADJ_W-3*EW)){adj_sel[ADJ_W-1]}}, adj_sel[ADJ_W-1:3*EW]};
          mul_y  = y_e;
          add_en = 1'b1;
          add_sh = 2'd2;
        end
        default: begin
          add_en = 1'b1;
          add_sh = 2'd3;
        end
      endcase
    end
  end

  always_comb begin
    prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    case (add_sh)
      2'd0:    addend = prod_ext;
      2'd1:    addend = prod_ext << EW;
      2'd2:    addend = prod_ext << (2 * EW);
      default: addend = prod_ext << (3 * EW);
    endcase
    acc_nxt  = acc_r + addend;
    det_zero = (det_r == '0);
    det_abs  = det_r[ACC_W-1] ? -det_r : det_r;
    adj_abs  = adj_sel[ADJ_W-1] ? -adj_sel : adj_sel;
  end

  assign div_req.start = (state_r == S_DIV) && !det_zero;
  assign div_req.num   = {adj_abs, {(2 * m4i_pkg::FB){1'b0}}};
  assign div_req.den   = det_abs;

  m4i_mul u_mul (
    .clk    (clk),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .prod_r (prod_r)
  );

  m4i_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    if (neg_r) begin
      fits = !div_rsp.ovf && !div_rsp.quo[Q_W-1] &&
             (!div_rsp.quo[EW-1] || (div_rsp.quo[EW-2:0] == '0));
    end else begin
      fits = !div_rsp.ovf && (div_rsp.quo[Q_W-1:EW-1] == 2'b00);
    end
    q_val = neg_r ? -div_rsp.quo[EW-1:0] : div_rsp.quo[EW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      load_cnt_r <= '0;
      p_r        <= '0;
      t_r        <= '0;
      s_r        <= '0;
      i_r        <= '0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_word.valid) begin
            store_r[load_cnt_r] <= in_word.element_value;
            load_cnt_r <= load_cnt_r + 4'd1;
            if (load_cnt_r == 4'd15) begin
              state_r <= S_COF;
              p_r     <= '0;
              t_r     <= '0;
              s_r     <= '0;
              acc_r   <= '0;
            end
          end
        end
        S_COF: begin
          if (s_r == 3'd0) begin
            a_r <= y_e;
          end
          if (s_r == 3'd2) begin
            plo_r <= prod_r[EW-1:0];
          end
          if (s_r == 3'd3) begin
            acc_r <= acc_nxt;
          end
          if (s_r == 3'd4) begin
            s_r <= '0;
            if (t_r == 3'd5) begin
              adj_r[p_r] <= acc_nxt[ADJ_W-1:0];
              acc_r <= '0;
              t_r   <= '0;
              if (p_r == 4'd15) begin
                state_r <= S_DET;
                i_r     <= '0;
              end else begin
                p_r <= p_r + 4'd1;
              end
            end else begin
              acc_r <= acc_nxt;
              t_r   <= t_r + 3'd1;
            end
          end else begin
            s_r <= s_r + 3'd1;
          end
        end
        S_DET: begin
          if (add_en) begin
            acc_r <= acc_nxt;
          end
          if (s_r == 3'd4) begin
            s_r <= '0;
            if (i_r == 2'd3) begin
              det_r   <= acc_nxt;
              state_r <= S_DIV;
              p_r     <= '0;
            end else begin
              i_r <= i_r + 2'd1;
            end
          end else begin
            s_r <= s_r + 3'd1;
          end
        end
        S_DIV: begin
          neg_r       <= adj_sel[ADJ_W-1] ^ det_r[ACC_W-1];
          out_index_r <= p_r;
          out_last_r  <= (p_r == 4'd15);
          out_sing_r  <= det_zero;
          if (det_zero) begin
            out_value_r <= '0;
            out_sat_r   <= 1'b0;
            state_r     <= S_OUT;
          end else begin
            state_r <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            out_sat_r <= !fits;
            if (fits) begin
              out_value_r <= q_val;
            end else begin
              out_value_r <= neg_r ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_word.ready) begin
            if (p_r == 4'd15) begin
              state_r <= S_LOAD;
            end else begin
              p_r     <= p_r + 4'd1;
              state_r <= S_DIV;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign in_word.ready          = (state_r == S_LOAD);
  assign out_word.valid         = (state_r == S_OUT);
  assign out_word.inverse_value = out_value_r;
  assign out_word.element_index = out_index_r;
  assign out_word.singular      = out_sing_r;
  assign out_word.saturated     = out_sat_r;
  assign out_word.last_of_run   = out_last_r;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_word.ready && out_word.valid))
    else $error("Input is taken while a result word is pending.");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && out_word.singular) |->
      (out_word.inverse_value == '0 && !out_word.saturated))
    else $error("A singular result word is not zero.");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && out_word.last_of_run) |-> (out_word.element_index == 4'd15))
    else $error("The last result word has the wrong index.");

  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && out_word.ready && out_word.last_of_run) |=> in_word.ready)
    else $error("Loading does not resume after the last result word.");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIVW))
    else $error("The divider finished outside of a division wait.");
`endif

endmodule
